### hdl/pwa_pkg.sv
// ----------------------------------------------------------------------------
// pwa_pkg
// Types and fixed constants shared by the pedestal waveform averager.
// ----------------------------------------------------------------------------
`default_nettype none

package pwa_pkg;

	localparam int GOAL_W = 12;
	localparam int CNT_W  = 10;
	localparam int SUM_W  = 20;
	localparam int AVG_W  = 10;
	localparam int VAL_W  = 10;
	localparam int CHANNELS = 4;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	localparam logic [1:0] SRC_CHIP0 = 2'd0;
	localparam logic [1:0] SRC_CHIP1 = 2'd1;
	localparam logic [1:0] SRC_ADC   = 2'd2;

	localparam logic [1:0] REG_GOAL_CHIP0 = 2'd0;
	localparam logic [1:0] REG_GOAL_CHIP1 = 2'd1;
	localparam logic [1:0] REG_GOAL_ADC   = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [1:0]       source;
		logic [1:0]       channel;
		logic [7:0]       sample_index;
		logic [VAL_W-1:0] sample_value;
		logic             event_first;
		logic             event_last;
	} pwa_req_t;

	typedef struct packed {
		logic [2:0]       pending_mask;
		logic             averages_ready;
		logic [CNT_W-1:0] chip0_count;
		logic [CNT_W-1:0] chip1_count;
		logic [CNT_W-1:0] adc_count;
		logic [AVG_W-1:0] average_out;
		logic             read_refused;
		logic             goal_error;
		logic             sample_ignored;
	} pwa_res_t;

	// handshake between sequencer and divider
	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  dividend;
		logic [GOAL_W-1:0] divisor;
	} pwa_div_cmd_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} pwa_div_sts_t;

endpackage

`default_nettype wire

### hdl/pwa_ram.sv
// ----------------------------------------------------------------------------
// pwa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pwa_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 1280
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hdl/pwa_div.sv
// ----------------------------------------------------------------------------
// pwa_div
// Restoring divider, one quotient bit per cycle, for sum / goal.
// ----------------------------------------------------------------------------
`default_nettype none

module pwa_div
	import pwa_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire pwa_div_cmd_t cmd,
	output pwa_div_sts_t      sts
);

	localparam int CW = $clog2(SUM_W + 1);

	logic [GOAL_W-1:0] rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [GOAL_W-1:0] dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic              done_q;
	logic [GOAL_W:0]   trial;
	logic              fits;

	always_comb begin
		trial = {rem_q, quo_q[SUM_W-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(SUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			quo_q <= cmd.dividend;
			dvs_q <= cmd.divisor;
		end else if (run_q) begin
			// remainder stays below the divisor, so the low bits suffice
			rem_q <= fits ? GOAL_W'(trial - {1'b0, dvs_q}) : trial[GOAL_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign sts.done     = done_q;
	assign sts.quotient = quo_q;

endmodule

`default_nettype wire

### hdl/pedestal_waveform_averager.sv
// ----------------------------------------------------------------------------
// pedestal_waveform_averager
// Per-sample pedestal sums and averages for two digitizers and a fast ADC.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req when start is high and busy is low. Each request
//   yields one result on result, marked by a one-cycle done strobe; the
//   receiver cannot stall, so the result must be taken in that cycle.
//   Goals are written on wr_en / wr_index / wr_data at any time the block
//   is idle; writes are taken at once, including during the clearing pass.
// Path from acceptance to done, by request:
//   ignored sample, refused or out-of-range read, status request: answered from idle
//   read of a stored average: one RAM read
//   accepted sample without averaging: read, modify, write back
//   accepted sample that updates the average: read, then SUM_W = 20
//     steps of the shared restoring divider, then write back
//   clear: a sweep that zeroes the sum/average RAM one entry per cycle,
//     DEPTH = 8*CHIP_SAMPLES + ADC_SAMPLES entries (1280 by default).
// Sums and averages share one RAM entry each; the digitizer channels come
// first, the fast ADC waveform follows. After reset the same sweep over all
// DEPTH entries runs with busy high and no result.
// ----------------------------------------------------------------------------
`default_nettype none

module pedestal_waveform_averager
	import pwa_pkg::*;
#(
	parameter int CHIP_SAMPLES = 128,
	parameter int ADC_SAMPLES  = 256,
	parameter int GOAL_LIMIT   = 1000,
	parameter int SAMPLE_BITS  = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire pwa_req_t          req,
	output logic                   done,
	output pwa_res_t               result,
	input  wire logic              wr_en,
	input  wire logic [1:0]        wr_index,
	input  wire logic [GOAL_W-1:0] wr_data
);

	localparam int CHIP_DEPTH = 2 * CHANNELS * CHIP_SAMPLES;
	localparam int DEPTH      = CHIP_DEPTH + ADC_SAMPLES;
	localparam int AW         = $clog2(DEPTH);
	localparam int WW         = SUM_W + AVG_W;
	localparam logic [SUM_W-1:0]  AVG_MAX = SUM_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [GOAL_W-1:0] LIMIT   = GOAL_W'(GOAL_LIMIT);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CLEAR = 6'b000010,
		ST_SUM   = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_FETCH = 6'b010000,
		ST_SPARE = 6'b100000
	} state_t;

	state_t            state_q;
	logic [GOAL_W-1:0] goal_q [3];
	logic [CNT_W-1:0]  cnt_q  [3];
	logic [2:0]        open_q;
	logic              ready_q;
	logic              valid_q;
	logic [AW-1:0]     clr_q;
	logic              clr_item_q;
	logic              done_q;
	logic [AVG_W-1:0]  avg_q;
	logic              refused_q;
	logic              gerr_q;
	logic              ignored_q;

	// sample in flight
	logic [AW-1:0]     addr_q;
	logic [VAL_W-1:0]  val_q;
	logic              need_div_q;
	logic [GOAL_W-1:0] dvs_q;
	logic [SUM_W-1:0]  sum_q;

	logic              accept;
	logic [1:0]        src;
	logic              in_range;
	logic [AW-1:0]     addr;
	logic [CNT_W-1:0]  cnt_n [3];
	logic              take;
	logic              gerr;
	logic              all_met_n;
	logic              sel_div;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WW-1:0]     ram_wdata;
	logic [WW-1:0]     ram_rdata;
	logic [SUM_W-1:0]  rd_sum;
	logic [SUM_W:0]    sum_wide;
	logic [SUM_W-1:0]  sum_sat;
	logic [AVG_W-1:0]  new_avg;

	pwa_div_cmd_t      div_cmd;
	pwa_div_sts_t      div_sts;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign src    = req.source;

	// decode the request against the live counts and goals
	always_comb begin
		in_range = (src[1] == 1'b0) ? ({1'b0, req.sample_index} < 9'(CHIP_SAMPLES))
		                            : ({1'b0, req.sample_index} < 9'(ADC_SAMPLES));
		if (src[1] == 1'b0) begin
			addr = AW'({src[0], req.channel}) * AW'(CHIP_SAMPLES) + AW'(req.sample_index);
		end else begin
			addr = AW'(CHIP_DEPTH) + AW'(req.sample_index);
		end
		gerr = (goal_q[0] > LIMIT) || (goal_q[1] > LIMIT) || (goal_q[2] > LIMIT);
		for (int s = 0; s < 3; s++) begin
			cnt_n[s] = cnt_q[s];
		end
		take = 1'b0;
		if (valid_q && src != 2'd3 && in_range) begin
			if (req.event_first) begin
				if ({2'b00, cnt_q[src]} < goal_q[src]) begin
					take = 1'b1;
					cnt_n[src] = cnt_q[src] + 1'b1;
				end
			end else begin
				take = open_q[src];
			end
		end
		all_met_n = 1'b1;
		for (int s = 0; s < 3; s++) begin
			if ({2'b00, cnt_n[s]} < goal_q[s]) begin
				all_met_n = 1'b0;
			end
		end
		sel_div = (src == 2'd3) ? 1'b0
		        : (goal_q[src] != '0) && ({2'b00, cnt_n[src]} >= goal_q[src]);
	end

	// read-modify arithmetic on the fetched entry
	always_comb begin
		rd_sum   = ram_rdata[WW-1:AVG_W];
		sum_wide = {1'b0, rd_sum} + (SUM_W + 1)'(val_q);
		sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
		new_avg  = (div_sts.quotient > AVG_MAX) ? AVG_MAX[AVG_W-1:0]
		                                        : div_sts.quotient[AVG_W-1:0];
	end

	always_comb begin
		div_cmd.start    = (state_q == ST_SUM) && need_div_q;
		div_cmd.dividend = sum_sat;
		div_cmd.divisor  = dvs_q;
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {sum_sat, ram_rdata[AVG_W-1:0]};
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_SUM: begin
				ram_we = !need_div_q;
			end
			ST_DIV: begin
				ram_we    = div_sts.done;
				ram_wdata = {sum_q, new_avg};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	pwa_ram #(
		.WIDTH(WW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	pwa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (div_cmd),
		.sts   (div_sts)
	);

	// goal registers: written whenever the port strobes, index 3 is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 3; s++) begin
				goal_q[s] <= '0;
			end
		end else if (wr_en) begin
			case (wr_index)
				REG_GOAL_CHIP0: goal_q[0] <= wr_data;
				REG_GOAL_CHIP1: goal_q[1] <= wr_data;
				REG_GOAL_ADC:   goal_q[2] <= wr_data;
				default:        ;
			endcase
		end
	end

	// sequencer and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			clr_item_q <= 1'b0;
			done_q     <= 1'b0;
			ready_q    <= 1'b0;
			valid_q    <= 1'b0;
			open_q     <= '0;
			for (int s = 0; s < 3; s++) begin
				cnt_q[s] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.kind)
							KIND_CLEAR: begin
								// zero the run, then sweep the RAM
								for (int s = 0; s < 3; s++) begin
									cnt_q[s] <= '0;
								end
								open_q     <= '0;
								valid_q    <= !gerr;
								ready_q    <= !gerr && (goal_q[0] == '0) &&
								              (goal_q[1] == '0) && (goal_q[2] == '0);
								clr_q      <= '0;
								clr_item_q <= 1'b1;
								state_q    <= ST_CLEAR;
							end
							KIND_SAMPLE: begin
								if (take) begin
									for (int s = 0; s < 3; s++) begin
										cnt_q[s] <= cnt_n[s];
									end
									if (req.event_last) begin
										open_q[src] <= 1'b0;
										if (all_met_n) begin
											ready_q <= 1'b1;
										end
									end else if (req.event_first) begin
										open_q[src] <= 1'b1;
									end
									state_q <= ST_SUM;
								end else begin
									done_q <= 1'b1;
								end
							end
							KIND_READ: begin
								if (ready_q && src != 2'd3 && in_range) begin
									state_q <= ST_FETCH;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						done_q     <= clr_item_q;
						clr_item_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				ST_SUM: begin
					if (need_div_q) begin
						state_q <= ST_DIV;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_FETCH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: request fields in flight and result flags
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q     <= addr;
			val_q      <= req.sample_value & AVG_MAX[VAL_W-1:0];
			need_div_q <= sel_div;
			dvs_q      <= (src == 2'd3) ? '0 : goal_q[src];
			avg_q      <= '0;
			refused_q  <= (req.kind == KIND_READ) && !ready_q;
			gerr_q     <= (req.kind == KIND_CLEAR) && gerr;
			ignored_q  <= (req.kind == KIND_SAMPLE) && !take;
		end
		if (state_q == ST_SUM) begin
			sum_q <= sum_sat;
		end
		if (state_q == ST_FETCH) begin
			avg_q <= ram_rdata[AVG_W-1:0];
		end
	end

	always_comb begin
		for (int s = 0; s < 3; s++) begin
			result.pending_mask[s] = valid_q && ({2'b00, cnt_q[s]} < goal_q[s]);
		end
		result.averages_ready = ready_q;
		result.chip0_count    = cnt_q[0];
		result.chip1_count    = cnt_q[1];
		result.adc_count      = cnt_q[2];
		result.average_out    = avg_q;
		result.read_refused   = refused_q;
		result.goal_error     = gerr_q;
		result.sample_ignored = ignored_q;
	end

	assign done = done_q;

endmodule

`default_nettype wire

### tb/pwa_checker.sv
// ----------------------------------------------------------------------------
// pwa_checker
// Watches the request, result and goal-write ports of the pedestal averager.
// Predicts every result from its own copy of sums, averages and counts, and
// compares each one field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwa_checker
	import pwa_pkg::*;
#(
	parameter int CHIP_SAMPLES = 128,
	parameter int ADC_SAMPLES  = 256,
	parameter int GOAL_LIMIT   = 1000,
	parameter int SAMPLE_BITS  = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  pwa_req_t          req,
	input  logic              done,
	input  pwa_res_t          result,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [GOAL_W-1:0] wr_data,
	output int                outstanding,
	output int                mismatches,
	output int                checked
);

	localparam int CHIP_DEPTH = 8 * CHIP_SAMPLES;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam int AVG_MAX = (1 << SAMPLE_BITS) - 1;

	logic [GOAL_W-1:0] goal [3];
	logic [SUM_W-1:0]  chip_sum [CHIP_DEPTH];
	logic [AVG_W-1:0]  chip_avg [CHIP_DEPTH];
	logic [SUM_W-1:0]  adc_sum [ADC_SAMPLES];
	logic [AVG_W-1:0]  adc_avg [ADC_SAMPLES];
	logic [CNT_W-1:0]  evt_cnt [3];
	logic              evt_open [3];
	logic              ready;
	logic              run_ok;
	pwa_res_t          expected_results [$];

	function automatic logic goals_met();
		for (int s = 0; s < 3; s++)
			if (evt_cnt[s] < goal[s])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void clear_run();
		for (int i = 0; i < CHIP_DEPTH; i++) begin
			chip_sum[i] = '0;
			chip_avg[i] = '0;
		end
		for (int i = 0; i < ADC_SAMPLES; i++) begin
			adc_sum[i] = '0;
			adc_avg[i] = '0;
		end
		for (int s = 0; s < 3; s++) begin
			evt_cnt[s]  = '0;
			evt_open[s] = 1'b0;
		end
		ready = 1'b0;
	endfunction

	// add one sample to a sum; refresh the average once the goal is reached
	function automatic void add_sample(inout logic [SUM_W-1:0] sum,
					   inout logic [AVG_W-1:0] avg,
					   input int val, input int src);
		int unsigned t;
		int unsigned q;
		t = int'(sum) + val;
		if (t > SUM_MAX)
			t = SUM_MAX;
		sum = t[SUM_W-1:0];
		if (goal[src] != 0 && evt_cnt[src] >= goal[src]) begin
			q = t / goal[src];
			if (q > AVG_MAX)
				q = AVG_MAX;
			avg = q[AVG_W-1:0];
		end
	endfunction

	function automatic pwa_res_t average_step(pwa_req_t r);
		pwa_res_t res;
		int src, idx, addr, val;
		logic in_range;
		res = '0;
		src = r.source;
		idx = r.sample_index;
		val = r.sample_value & AVG_MAX;
		case (kind_t'(r.kind))
			KIND_CLEAR: begin
				clear_run();
				res.goal_error = goal[0] > GOAL_LIMIT || goal[1] > GOAL_LIMIT ||
					goal[2] > GOAL_LIMIT;
				run_ok = !res.goal_error;
				if (run_ok && goals_met())
					ready = 1'b1;
			end
			KIND_SAMPLE: begin
				in_range = (src < 2) ? (idx < CHIP_SAMPLES) : (idx < ADC_SAMPLES);
				if (!run_ok || src > 2 || !in_range)
					res.sample_ignored = 1'b1;
				else if (r.event_first) begin
					if (evt_cnt[src] < goal[src]) begin
						evt_cnt[src]  = evt_cnt[src] + 1'b1;
						evt_open[src] = 1'b1;
					end else
						res.sample_ignored = 1'b1;
				end else if (!evt_open[src])
					res.sample_ignored = 1'b1;
				if (!res.sample_ignored) begin
					if (src < 2) begin
						addr = (src * CHANNELS + r.channel) * CHIP_SAMPLES + idx;
						add_sample(chip_sum[addr], chip_avg[addr], val, src);
					end else
						add_sample(adc_sum[idx], adc_avg[idx], val, src);
					if (r.event_last) begin
						evt_open[src] = 1'b0;
						if (goals_met())
							ready = 1'b1;
					end
				end
			end
			KIND_READ: begin
				if (!ready)
					res.read_refused = 1'b1;
				else if (src < 2) begin
					if (idx < CHIP_SAMPLES)
						res.average_out =
							chip_avg[(src * CHANNELS + r.channel) * CHIP_SAMPLES + idx];
				end else if (src == 2 && idx < ADC_SAMPLES)
					res.average_out = adc_avg[idx];
			end
			default: ;
		endcase
		for (int s = 0; s < 3; s++)
			if (run_ok && evt_cnt[s] < goal[s])
				res.pending_mask[s] = 1'b1;
		res.averages_ready = ready;
		res.chip0_count    = evt_cnt[0];
		res.chip1_count    = evt_cnt[1];
		res.adc_count      = evt_cnt[2];
		return res;
	endfunction

	task automatic field_check(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("result field %s: expected %0d, got %0d", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pwa_res_t e;
		if (!arst_n) begin
			for (int s = 0; s < 3; s++)
				goal[s] = '0;
			clear_run();
			run_ok = 1'b0;
			expected_results.delete();
			outstanding = 0;
			mismatches  = 0;
			checked     = 0;
		end else begin
			// retire the oldest request first: its result may share an edge with
			// the next acceptance
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					e = expected_results.pop_front();
					field_check("pending_mask", e.pending_mask, result.pending_mask);
					field_check("averages_ready", e.averages_ready, result.averages_ready);
					field_check("chip0_count", e.chip0_count, result.chip0_count);
					field_check("chip1_count", e.chip1_count, result.chip1_count);
					field_check("adc_count", e.adc_count, result.adc_count);
					field_check("average_out", e.average_out, result.average_out);
					field_check("read_refused", e.read_refused, result.read_refused);
					field_check("goal_error", e.goal_error, result.goal_error);
					field_check("sample_ignored", e.sample_ignored, result.sample_ignored);
					checked++;
				end
			end
			if (wr_en && wr_index < 3)
				goal[wr_index] = wr_data;
			if (start && !busy)
				expected_results.push_back(average_step(req));
			outstanding = expected_results.size();
		end
	end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the pedestal waveform averager. A directed opening walks the
// goal limits, every request kind and the refusal cases; random runs then
// feed well-formed events with random content, broken events, reads and
// noise under several goal settings. pwa_checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import pwa_pkg::*;

	localparam int REQ_W = $bits(pwa_req_t);

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	pwa_req_t          req = '0;
	logic              done;
	pwa_res_t          result;
	logic              wr_en = 1'b0;
	logic [1:0]        wr_index = '0;
	logic [GOAL_W-1:0] wr_data = '0;
	int                outstanding, mismatches, checked;
	int                idle_pct;
	int                requests_sent;
	int                goal_sets;

	always #5 clk = ~clk;

	pedestal_waveform_averager dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data)
	);

	pwa_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .outstanding(outstanding), .mismatches(mismatches),
		.checked(checked)
	);

	function automatic pwa_req_t mk_req(kind_t k, logic [1:0] src, logic [1:0] ch,
					     int idx, int val, bit first, bit last);
		pwa_req_t r;
		r.kind         = k;
		r.source       = src;
		r.channel      = ch;
		r.sample_index = idx[7:0];
		r.sample_value = val[VAL_W-1:0];
		r.event_first  = first;
		r.event_last   = last;
		return r;
	endfunction

	// Present one request at a falling edge and hold it until accepted.
	// start stays high on return so a back-to-back request needs no toggle.
	task automatic send(pwa_req_t r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req   <= r;
		// busy holds until the next rising edge, which takes the request once low
		while (busy)
			@(negedge clk);
		@(negedge clk);
		requests_sent++;
	endtask

	// Drop start and wait until every result has come back.
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0 || busy)
			@(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	// Write all three goals while the block is idle.
	task automatic set_goals(int g0, int g1, int g2);
		int g [3];
		g = '{g0, g1, g2};
		drain();
		for (int i = 0; i < 3; i++) begin
			wr_en    <= 1'b1;
			wr_index <= (i == 0) ? REG_GOAL_CHIP0 : (i == 1) ? REG_GOAL_CHIP1 : REG_GOAL_ADC;
			wr_data  <= g[i][GOAL_W-1:0];
			@(negedge clk);
		end
		wr_en <= 1'b0;
		goal_sets++;
	endtask

	function automatic int pick_goal();
		int p;
		p = $urandom_range(99);
		if (p < 5)
			return $urandom_range(GOAL_W == 12 ? 1001 : 1001, 4095);
		if (p < 12)
			return 0;
		return $urandom_range(1, 3);
	endfunction

	// One event of a source: well-formed unless broken is set, random content.
	task automatic random_event(int budget);
		logic [1:0] src, ch;
		int len, idx;
		bit broken;
		src    = 2'($urandom_range(2));
		ch     = 2'($urandom_range(3));
		len    = $urandom_range(1, 5);
		broken = ($urandom_range(9) == 0);
		for (int i = 0; i < len && i < budget; i++) begin
			idx = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(7);
			send(mk_req(KIND_SAMPLE, src, ch, idx, $urandom_range(1023),
				(i == 0) && !broken, i == len - 1));
		end
	endtask

	initial begin
		#5ms;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		int n, run_items;
		pwa_req_t noise;
		bit paused;
		requests_sent = 0;
		goal_sets     = 0;
		idle_pct      = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (busy)
			@(negedge clk);

		// directed: nothing valid before the first clear
		send(mk_req(KIND_READ, SRC_CHIP0, 2'd0, 0, 0, 0, 0));
		send(mk_req(KIND_SAMPLE, SRC_CHIP0, 2'd0, 0, 1023, 1, 1));
		send(mk_req(KIND_NONE, SRC_ADC, 2'd3, 255, 1023, 1, 1));
		// all goals zero: ready at once after a clear
		send(mk_req(KIND_CLEAR, SRC_CHIP0, 2'd0, 0, 0, 0, 0));
		send(mk_req(KIND_READ, SRC_ADC, 2'd0, 255, 0, 0, 0));

		// goals above the limit: run invalid, samples dropped
		set_goals(4095, 1001, 0);
		send(mk_req(KIND_CLEAR, SRC_CHIP0, 2'd0, 0, 0, 0, 0));
		send(mk_req(KIND_SAMPLE, SRC_CHIP1, 2'd1, 5, 7, 1, 1));

		// goals at the limit: valid run, index range edges
		set_goals(1000, 1000, 1000);
		send(mk_req(KIND_CLEAR, SRC_CHIP0, 2'd0, 0, 0, 0, 0));
		send(mk_req(KIND_SAMPLE, SRC_CHIP0, 2'd3, 127, 1023, 1, 0));
		send(mk_req(KIND_SAMPLE, SRC_CHIP0, 2'd3, 128, 1023, 0, 1));
		send(mk_req(KIND_SAMPLE, SRC_CHIP1, 2'd0, 3, 1, 0, 1));
		send(mk_req(KIND_SAMPLE, SRC_ADC, 2'd0, 255, 1023, 1, 1));

		// goals of one: averages land, ready after the last source ends
		set_goals(1, 1, 1);
		send(mk_req(KIND_CLEAR, SRC_CHIP0, 2'd0, 0, 0, 0, 0));
		send(mk_req(KIND_SAMPLE, SRC_CHIP0, 2'd0, 0, 1023, 1, 1));
		send(mk_req(KIND_SAMPLE, SRC_CHIP1, 2'd2, 64, 512, 1, 1));
		send(mk_req(KIND_READ, SRC_CHIP0, 2'd0, 0, 0, 0, 0));
		send(mk_req(KIND_SAMPLE, SRC_ADC, 2'd0, 128, 341, 1, 1));
		send(mk_req(KIND_READ, SRC_CHIP0, 2'd0, 0, 0, 0, 0));
		send(mk_req(KIND_READ, SRC_CHIP0, 2'd0, 200, 0, 0, 0));
		send(mk_req(KIND_READ, 2'd3, 2'd0, 0, 0, 0, 0));
		send(mk_req(KIND_SAMPLE, 2'd3, 2'd0, 0, 5, 1, 1));
		send(mk_req(KIND_SAMPLE, SRC_CHIP0, 2'd0, 0, 9, 1, 1));
		send(mk_req(KIND_NONE, SRC_CHIP0, 2'd0, 0, 0, 0, 0));

		// random runs under shifting idle rates
		n         = 0;
		run_items = 1000;
		paused    = 1'b0;
		while (n < 750) begin
			idle_pct = (n < 250) ? 21 : (n < 500) ? 52 : 0;
			if (run_items >= 60) begin
				set_goals(pick_goal(), pick_goal(), pick_goal());
				send(mk_req(KIND_CLEAR, SRC_CHIP0, 2'd0, 0, 0, 0, 0));
				run_items = 0;
				n++;
			end
			if (!paused && n > 400) begin
				// hold off until the pipeline is empty, then resume
				drain();
				paused = 1'b1;
			end
			case ($urandom_range(9))
				0: begin
					noise = REQ_W'($urandom);
					if (noise.kind == KIND_CLEAR)
						noise.kind = KIND_NONE;
					send(noise);
					n++;
					run_items++;
				end
				1, 2: begin
					send(mk_req(KIND_READ, 2'($urandom_range(3)), 2'($urandom_range(3)),
						($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7),
						$urandom_range(1023), 1'($urandom_range(1)),
						1'($urandom_range(1))));
					n++;
					run_items++;
				end
				default: begin
					random_event(750 - n);
					n += 3;
					run_items += 3;
				end
			endcase
		end
		drain();

		$display("tb_top: %0d requests in %0d goal settings, %0d results compared",
			requests_sent, goal_sets, checked);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
